>>> sv/dqs_pkg.sv
// Shared types and constants of the deque with sorted insert.
package dqs_pkg;

  // Default number of entries and the fixed field widths.
  localparam int unsigned DepthDef = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned StatusW  = 2;

  // Request kinds carried on the slave-side tuser.
  typedef enum logic [ReqW-1:0] {
    REQ_INSERT    = 2'd0,
    REQ_SORTED    = 2'd1,
    REQ_POP_FRONT = 2'd2,
    REQ_POP_BACK  = 2'd3
  } req_e;

  // Result status carried on the master-side tuser.
  typedef enum logic [StatusW-1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_REFUSED = 2'd3
  } status_e;

  // What a cell does with its entry in this cycle.
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_TAKE_PREV = 2'd2,
    CELL_TAKE_NEXT = 2'd3
  } cell_op_e;

  // Compare flags that a cell reports against the incoming value.
  typedef struct packed {
    logic entry_lt; // entry < value
    logic value_lt; // value < entry
  } cell_cmp_t;

endpackage

>>> sv/dqs_cell.sv
// One storage cell of the deque: holds an entry, shifts it and compares it.
module dqs_cell (
  input  logic                             clk_i,
  input  dqs_pkg::cell_op_e                op_i,
  input  logic signed [dqs_pkg::DataW-1:0] value_i,
  input  logic signed [dqs_pkg::DataW-1:0] prev_i,
  input  logic signed [dqs_pkg::DataW-1:0] next_i,
  output logic signed [dqs_pkg::DataW-1:0] entry_o,
  output dqs_pkg::cell_cmp_t               cmp_o
);

  logic signed [dqs_pkg::DataW-1:0] entry_q;
  logic signed [dqs_pkg::DataW-1:0] entry_d;

  // Select the new entry from the value, a neighbor or the cell itself.
  always_comb begin
    case (op_i)
      dqs_pkg::CELL_LOAD:      entry_d = value_i;
      dqs_pkg::CELL_TAKE_PREV: entry_d = prev_i;
      dqs_pkg::CELL_TAKE_NEXT: entry_d = next_i;
      default:                 entry_d = entry_q;
    endcase
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Signed compares against the value of the current request.
  assign cmp_o.entry_lt = (entry_q < value_i);
  assign cmp_o.value_lt = (value_i < entry_q);
  assign entry_o        = entry_q;

endmodule

>>> sv/dqs_ctrl.sv
// Control of the deque: fill count, insert position, cell commands and result register.
module dqs_ctrl #(
  parameter int unsigned Depth  = dqs_pkg::DepthDef,
  parameter int unsigned CountW = $clog2(Depth + 1),
  parameter int unsigned IdxW   = $clog2(Depth)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             stack_mode_i,
  input  logic                             req_valid_i,
  output logic                             req_ready_o,
  input  dqs_pkg::req_e                    req_type_i,
  input  dqs_pkg::cell_cmp_t               cmp_i   [Depth],
  input  logic signed [dqs_pkg::DataW-1:0] entry_i [Depth],
  output dqs_pkg::cell_op_e                op_o    [Depth],
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic signed [dqs_pkg::DataW-1:0] popped_value_o,
  output dqs_pkg::status_e                 status_o,
  output logic [CountW-1:0]                entry_count_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              accept;
  logic              full, empty;
  logic              ins_ok, popf_ok, popb_ok;
  dqs_pkg::status_e  status;
  logic [Depth-1:0]  cand, here, after;
  logic              seen;
  logic [CountW-1:0] last_idx;
  logic signed [dqs_pkg::DataW-1:0] popped;

  logic                             res_valid_q;
  logic signed [dqs_pkg::DataW-1:0] popped_q;
  dqs_pkg::status_e                 status_q;
  logic [CountW-1:0]                res_count_q;

  assign req_ready_o = !res_valid_q || res_ready_i;
  assign accept      = req_valid_i && req_ready_o;
  assign full        = (count_q == CountW'(Depth));
  assign empty       = (count_q == '0);

  // Decide the outcome of the request.
  always_comb begin
    status  = dqs_pkg::ST_DONE;
    ins_ok  = 1'b0;
    popf_ok = 1'b0;
    popb_ok = 1'b0;
    unique case (req_type_i)
      dqs_pkg::REQ_INSERT: begin
        if (full) status = dqs_pkg::ST_FULL;
        else      ins_ok = 1'b1;
      end
      dqs_pkg::REQ_SORTED: begin
        if (stack_mode_i) status = dqs_pkg::ST_REFUSED;
        else if (full)    status = dqs_pkg::ST_FULL;
        else              ins_ok = 1'b1;
      end
      dqs_pkg::REQ_POP_FRONT: begin
        if (empty) status  = dqs_pkg::ST_EMPTY;
        else       popf_ok = 1'b1;
      end
      default: begin
        if (empty) status  = dqs_pkg::ST_EMPTY;
        else       popb_ok = 1'b1;
      end
    endcase
  end

  // Candidate cells for the insert; the first candidate along the chain wins.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      if (req_type_i == dqs_pkg::REQ_SORTED) begin
        if (i == 0) begin
          cand[i] = empty || cmp_i[i].value_lt;
        end else begin
          cand[i] = (CountW'(i) == count_q) ||
                    ((CountW'(i) < count_q) && !cmp_i[i].entry_lt);
        end
      end else if (stack_mode_i) begin
        cand[i] = (i == 0);
      end else begin
        cand[i] = (CountW'(i) == count_q);
      end
    end
  end

  // Ripple through the cells: each learns if the gap opens here or ahead of it.
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      here[i]  = cand[i] && !seen;
      after[i] = seen;
      seen     = seen || cand[i];
    end
  end

  // Per-cell commands.
  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      op_o[i] = dqs_pkg::CELL_HOLD;
      if (accept && ins_ok) begin
        if (here[i])       op_o[i] = dqs_pkg::CELL_LOAD;
        else if (after[i]) op_o[i] = dqs_pkg::CELL_TAKE_PREV;
      end else if (accept && popf_ok && (i < Depth - 1)) begin
        op_o[i] = dqs_pkg::CELL_TAKE_NEXT;
      end
    end
  end

  // Value leaving the deque and the next fill count.
  assign last_idx = count_q - CountW'(1);

  always_comb begin
    popped  = '0;
    count_d = count_q;
    if (popf_ok) begin
      popped  = entry_i[0];
      count_d = count_q - CountW'(1);
    end else if (popb_ok) begin
      popped  = entry_i[last_idx[IdxW-1:0]];
      count_d = count_q - CountW'(1);
    end else if (ins_ok) begin
      count_d = count_q + CountW'(1);
    end
  end

  // Fill count and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q    <= popped;
      status_q    <= status;
      res_count_q <= count_d;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign entry_count_o  = res_count_q;

  // The fill count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("fill count above depth");

  // A front pop on a non-empty deque removes exactly one entry.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_type_i == dqs_pkg::REQ_POP_FRONT) && !empty
    |=> count_q == $past(count_q) - CountW'(1))
    else $error("front pop did not decrement the count");

  // Every accepted request leaves a result behind.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_valid_q)
    else $error("accepted request produced no result");

  // A full status is only reported with a full deque.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (status_q == dqs_pkg::ST_FULL) |-> res_count_q == CountW'(Depth))
    else $error("full status with room left");

endmodule

>>> sv/deque_with_sorted_insert.sv
// Top level of the deque with sorted insert: mode register, cell chain and control.
//
// The block takes one request per clock cycle and returns its result in the
// following cycle from an output register; it stalls only while that result is
// not taken. Entries live in a chain of Depth cells that shift in place,
// so every insert, sorted insert and pop completes in the cycle it is accepted. The
// longest path is the sorted-insert position search, a one-bit ripple through
// all cells after their signed compares. Requests arrive with the kind in
// s_axis_tuser and the value in s_axis_tdata; results carry the status in
// m_axis_tuser and the popped value and entry count in m_axis_tdata.
module deque_with_sorted_insert #(
  parameter int unsigned Depth  = dqs_pkg::DepthDef,
  parameter int unsigned CountW = $clog2(Depth + 1),
  parameter int unsigned OutW   = ((dqs_pkg::DataW + CountW + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Mode register write channel.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,      // stack_mode
  // Request stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [dqs_pkg::DataW-1:0]   s_axis_tdata,    // data_value
  input  logic [dqs_pkg::ReqW-1:0]    s_axis_tuser,    // req_type
  // Result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [OutW-1:0]             m_axis_tdata,    // popped_value, entry_count
  output logic [dqs_pkg::StatusW-1:0] m_axis_tuser     // status
);

  logic                             stack_mode_q;
  logic signed [dqs_pkg::DataW-1:0] value;
  dqs_pkg::req_e                    req_type;
  dqs_pkg::cell_op_e                op    [Depth];
  dqs_pkg::cell_cmp_t               cmp   [Depth];
  logic signed [dqs_pkg::DataW-1:0] entry [Depth];
  logic signed [dqs_pkg::DataW-1:0] popped_value;
  dqs_pkg::status_e                 status;
  logic [CountW-1:0]                entry_count;

  // Mode register; writes must arrive only while the deque is idle, which the block itself does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      stack_mode_q <= cfg_data_i;
    end
  end

  assign value    = s_axis_tdata;
  assign req_type = dqs_pkg::req_e'(s_axis_tuser);

  // Chain of cells; the ends take their own entry as the missing neighbor.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    dqs_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op[g]),
      .value_i (value),
      .prev_i  (entry[(g == 0) ? 0 : g - 1]),
      .next_i  (entry[(g == Depth - 1) ? g : g + 1]),
      .entry_o (entry[g]),
      .cmp_o   (cmp[g])
    );
  end

  dqs_ctrl #(
    .Depth  (Depth),
    .CountW (CountW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stack_mode_i   (stack_mode_q),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_type_i     (req_type),
    .cmp_i          (cmp),
    .entry_i        (entry),
    .op_o           (op),
    .res_valid_o    (m_axis_tvalid),
    .res_ready_i    (m_axis_tready),
    .popped_value_o (popped_value),
    .status_o       (status),
    .entry_count_o  (entry_count)
  );

  // Pack the result fields, lowest first, zero-filled to whole bytes.
  assign m_axis_tdata = OutW'({entry_count, popped_value});
  assign m_axis_tuser = status;

endmodule

>>> sim/deque_with_sorted_insert_tb.sv
// Self-checking testbench for the deque with sorted insert, driven through its stream ports.
`timescale 1ns / 100ps

module deque_with_sorted_insert_tb;
  import dqs_pkg::*;

  localparam int unsigned CountW     = $clog2(DepthDef + 1);
  localparam int unsigned OutW       = ((DataW + CountW + 7) / 8) * 8;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned NumPhases  = 11;
  localparam int unsigned CycleLimit = 200000;

  // One result as the block reports it.
  typedef struct packed {
    logic [DataW-1:0]  popped_value;
    status_e           status;
    logic [CountW-1:0] entry_count;
  } deque_result_t;

  // Mirrors the deque contents and mode, and holds the results still owed.
  class deque_tracker;
    logic signed [DataW-1:0] entries[$];
    bit                      stack_mode;
    deque_result_t           owed_results[$];
    int                      errors;

    function new();
      stack_mode = 1'b0;
      errors     = 0;
    endfunction

    function void set_mode(bit mode);
      stack_mode = mode;
    endfunction

    function int owed();
      return owed_results.size();
    endfunction

    // Applies one request to the mirrored deque and returns its result.
    function deque_result_t apply_request(req_e req, logic signed [DataW-1:0] value);
      deque_result_t res;
      int            pos;
      res.popped_value = '0;
      res.status       = ST_DONE;
      case (req)
        REQ_INSERT: begin
          if (entries.size() >= DepthDef) res.status = ST_FULL;
          else if (stack_mode) entries.push_front(value);
          else entries.push_back(value);
        end
        REQ_SORTED: begin
          if (stack_mode) begin
            res.status = ST_REFUSED;
          end else if (entries.size() >= DepthDef) begin
            res.status = ST_FULL;
          end else if (entries.size() == 0 || value < entries[0]) begin
            entries.push_front(value);
          end else begin
            // The front entry is never passed over here, so ties land after it.
            pos = 1;
            while (pos < entries.size() && entries[pos] < value) pos++;
            entries.insert(pos, value);
          end
        end
        default: begin
          if (entries.size() == 0) res.status = ST_EMPTY;
          else if (req == REQ_POP_FRONT) res.popped_value = entries.pop_front();
          else res.popped_value = entries.pop_back();
        end
      endcase
      res.entry_count = CountW'(entries.size());
      return res;
    endfunction

    function void note_request(req_e req, logic signed [DataW-1:0] value);
      owed_results.push_back(apply_request(req, value));
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check_result(deque_result_t got);
      deque_result_t want;
      if (owed_results.size() == 0) begin
        $error("result transaction arrived with no request outstanding");
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got.popped_value !== want.popped_value) begin
        $error("popped_value: expected %0d, got %0d",
               $signed(want.popped_value), $signed(got.popped_value));
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_data_i    = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DataW-1:0]  s_axis_tdata  = '0;
  logic [ReqW-1:0]   s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutW-1:0]   m_axis_tdata;
  logic [StatusW-1:0] m_axis_tuser;

  deque_tracker tracker = new();
  bit           calm         = 1'b0;
  bit           stall_active = 1'b0;
  int unsigned  items_sent   = 0;
  int unsigned  cycle_count  = 0;

  deque_with_sorted_insert uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("deque_with_sorted_insert_tb: done, errors");
      $finish;
    end
  end

  // The result side takes transactions with random back-pressure, except in calm phases and during the stall.
  always @(posedge clk_i) begin
    if (stall_active) m_axis_tready <= 1'b0;
    else if (calm) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) >= 15);
  end

  // Every accepted result transaction goes to the tracker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_result('{popped_value: m_axis_tdata[DataW-1:0],
                             status:       status_e'(m_axis_tuser),
                             entry_count:  m_axis_tdata[DataW +: CountW]});
    end
  end

  // A long hold-off on the result side fills the block and stalls its input.
  initial begin
    wait (items_sent >= 350);
    @(posedge clk_i);
    stall_active <= 1'b1;
    repeat (80) @(posedge clk_i);
    stall_active <= 1'b0;
  end

  // Offers one request and waits until the block accepts it.
  task automatic send_request(req_e req, logic [DataW-1:0] value);
    if (!calm && $urandom_range(0, 99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.note_request(req, value);
    items_sent++;
  endtask

  // Writes the mode once every owed result has come back.
  task automatic write_mode(bit mode);
    s_axis_tvalid <= 1'b0;
    while (tracker.owed() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.set_mode(mode);
    cfg_valid_i <= 1'b0;
  endtask

  // Small values in four of ten picks so ties are common, plus the extremes and full-range values.
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DataW'($signed($urandom_range(0, 8)) - 4);
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Chooses a request kind, leaning toward inserts or pops by phase.
  function automatic req_e pick_request(int unsigned lean);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (lean)
      0: return (roll < 75) ? req_e'(2'($urandom_range(0, 1))) : req_e'(2'($urandom_range(2, 3)));
      1: return (roll < 75) ? req_e'(2'($urandom_range(2, 3))) : req_e'(2'($urandom_range(0, 1)));
      default: return req_e'(2'($urandom_range(0, 3)));
    endcase
  endfunction

  initial begin
    bit mode;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Queue mode after reset: empty pops, sorted inserts at both ends and ties.
    send_request(REQ_POP_FRONT, 32'hFFFF_FFFF);
    send_request(REQ_POP_BACK,  32'h0000_0000);
    send_request(REQ_SORTED,    32'h0000_0000);
    send_request(REQ_SORTED,    32'h8000_0000);
    send_request(REQ_SORTED,    32'h7FFF_FFFF);
    send_request(REQ_SORTED,    32'h8000_0000);
    send_request(REQ_SORTED,    32'h0000_0000);
    send_request(REQ_INSERT,    32'h0000_0005);
    send_request(REQ_POP_BACK,  32'h5555_5555);
    send_request(REQ_POP_FRONT, 32'hAAAA_AAAA);

    // Switch to stack mode with entries held.
    write_mode(1'b1);
    send_request(REQ_SORTED,    32'h0000_0003);
    send_request(REQ_INSERT,    32'hFFFF_FFFF);
    send_request(REQ_POP_FRONT, 32'h0000_0000);
    send_request(REQ_POP_BACK,  32'h0000_0000);
    send_request(REQ_INSERT,    32'h7FFF_FFFF);

    // Random phases alternate fill-heavy, drain-heavy and balanced traffic.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) mode = 1'b0;
      else if (phase == 1) mode = 1'b1;
      else mode = bit'($urandom_range(0, 1));
      write_mode(mode);
      calm = (phase == 5 || phase == 6);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        send_request(pick_request(phase % 3), pick_value());
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain, let the output register settle, then report.
    while (tracker.owed() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("deque_with_sorted_insert_tb: done, clean");
    end else begin
      $display("deque_with_sorted_insert_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> deque_with_sorted_insert.f
sv/dqs_pkg.sv
sv/dqs_cell.sv
sv/dqs_ctrl.sv
sv/deque_with_sorted_insert.sv
sim/deque_with_sorted_insert_tb.sv
